### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros of the RTL, included by yuv_box_downsampler_top.
// Define ASSERT_OFF to compile every assertion away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/ybd_pkg.sv
// ----------------------------------------------------------------------------
// ybd_pkg
// Types, constants and small functions of the YUV box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package ybd_pkg;

  // Configuration register widths and limits.
  localparam int CFG_W        = 11;
  localparam int FACTOR_REG_W = 4;
  localparam int ROW_W        = 10;
  localparam int HEIGHT_LIMIT = 1024;

  // Register indexes on the configuration port (word addresses).
  localparam logic [1:0] REG_OUT_WIDTH    = 2'd0;
  localparam logic [1:0] REG_OUT_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_BLOCK_FACTOR = 2'd2;

  // Output queue size.
  localparam int FIFO_PW    = 3;
  localparam int FIFO_DEPTH = 1 << FIFO_PW;

  // RGB to YUV, Q14.
  localparam logic [31:0] Y_R = 32'd4899;
  localparam logic [31:0] Y_G = 32'd9617;
  localparam logic [31:0] Y_B = 32'd1868;
  localparam logic [31:0] U_R = 32'd2411;
  localparam logic [31:0] U_G = 32'd4733;
  localparam logic [31:0] U_B = 32'd7143;
  localparam logic [31:0] V_R = 32'd10076;
  localparam logic [31:0] V_G = 32'd8438;
  localparam logic [31:0] V_B = 32'd1639;

  // YUV to RGB, Q14 on Q14 averages gives Q28.
  localparam logic signed [49:0] R_V = 50'sd18675;
  localparam logic signed [49:0] G_U = 50'sd6466;
  localparam logic signed [49:0] G_V = 50'sd9513;
  localparam logic signed [49:0] B_U = 50'sd33294;

  // One row accumulator entry: Y, U and V sums, two's complement.
  typedef struct packed {
    logic [31:0] y;
    logic [31:0] u;
    logic [31:0] v;
  } yuv_t;

  // One finished output pixel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_frame;
  } out_pix_t;

  // Rounded Q16 reciprocal of the block area, factor 1 to 16.
  function automatic logic [16:0] recip_q16(input logic [4:0] f);
    logic [16:0] r;
    case (f)
      5'd1:    r = 17'd65536;
      5'd2:    r = 17'd16384;
      5'd3:    r = 17'd7282;
      5'd4:    r = 17'd4096;
      5'd5:    r = 17'd2621;
      5'd6:    r = 17'd1820;
      5'd7:    r = 17'd1337;
      5'd8:    r = 17'd1024;
      5'd9:    r = 17'd809;
      5'd10:   r = 17'd655;
      5'd11:   r = 17'd542;
      5'd12:   r = 17'd455;
      5'd13:   r = 17'd388;
      5'd14:   r = 17'd334;
      5'd15:   r = 17'd291;
      5'd16:   r = 17'd256;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // Q28 channel value to a byte: negative gives zero, large values saturate.
  function automatic logic [7:0] to_byte(input logic signed [51:0] q);
    logic [7:0] b;
    if (q <= 52'sd0) begin
      b = 8'd0;
    end else if (|q[51:36]) begin
      b = 8'd255;
    end else begin
      b = q[35:28];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/ybd_intf.sv
// ----------------------------------------------------------------------------
// ybd_intf
// Pixel stream interfaces of the YUV box downsampler: RGB in, RGB out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ybd_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ybd_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       end_of_frame;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output end_of_frame, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input end_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/ybd_ram.sv
// ----------------------------------------------------------------------------
// ybd_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ybd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a read at the written address returns the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/yuv_box_downsampler_top.sv
// ----------------------------------------------------------------------------
// yuv_box_downsampler_top
// Box-filter downsampler of an RGB raster stream, averaging done in YUV.
// ----------------------------------------------------------------------------
// Usage:
// pix_in takes one RGB pixel per transaction, raster order, rows of
// block_factor*out_width pixels. pix_out gives one averaged RGB pixel per
// transaction, at the last pixel of each block_factor x block_factor block,
// with end_of_frame set on the last pixel of output row out_height-1.
// The APB port writes out_width, out_height and block_factor at 0x0, 0x4 and
// 0x8; write them only while no pixel is in flight.
// Throughput is one input pixel per cycle unless the divider or the queue
// reservation holds pix_in off: the Y/U/V row accumulators sit in one RAM
// with a registered read, and back-to-back hits on the same column are
// forwarded from the previous write. Results pass registers s1 to s4.
// Each configuration write re-derives the column position from the pixel
// counter with a bit-serial divider; pix_in is held off until the divider
// has stepped through every bit of the counter.
// Reset clears the counters and the output queue; the accumulator RAM is not
// cleared, since every block overwrites its column on its first pixel.
// When the receiver stalls, results queue in an 8-entry buffer and pix_in
// stops accepting once every queue slot is claimed by a pending result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module yuv_box_downsampler_top
  import ybd_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_FACTOR    = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ybd_pix_in_if.sink       pix_in,
  ybd_pix_out_if.source    pix_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW   = $clog2(MAX_OUT_WIDTH);
  localparam int WW   = $clog2(MAX_OUT_WIDTH + 1);
  localparam int FW   = $clog2(MAX_FACTOR + 1);
  localparam int ICW  = $clog2(MAX_FACTOR * MAX_OUT_WIDTH);
  localparam int CMPW = (ICW > WW) ? ICW : WW;
  localparam int CNTW = $clog2(ICW + 1);
  localparam int HW   = ROW_W + 1;
  localparam int YW   = $bits(yuv_t);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } ybd_state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]        out_width_q;
  logic [CFG_W-1:0]        out_height_q;
  logic [FACTOR_REG_W-1:0] block_factor_q;
  logic                    cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q    <= CFG_W'(1);
      out_height_q   <= CFG_W'(1);
      block_factor_q <= FACTOR_REG_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_OUT_WIDTH:    out_width_q    <= pwdata[CFG_W-1:0];
        REG_OUT_HEIGHT:   out_height_q   <= pwdata[CFG_W-1:0];
        REG_BLOCK_FACTOR: block_factor_q <= pwdata[FACTOR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      REG_OUT_WIDTH:    prdata = 32'(out_width_q);
      REG_OUT_HEIGHT:   prdata = 32'(out_height_q);
      REG_BLOCK_FACTOR: prdata = 32'(block_factor_q);
      default:          prdata = 32'd0;
    endcase
  end

  // Effective (clamped) configuration.
  logic [FW-1:0] f_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (block_factor_q == '0) begin
      f_eff = FW'(1);
    end else if (32'(block_factor_q) > 32'(MAX_FACTOR)) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(block_factor_q);
    end

    if (out_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(out_width_q) > 32'(MAX_OUT_WIDTH)) begin
      w_eff = WW'(MAX_OUT_WIDTH);
    end else begin
      w_eff = WW'(out_width_q);
    end

    if (out_height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(out_height_q) > 32'(HEIGHT_LIMIT)) begin
      h_eff = HW'(HEIGHT_LIMIT);
    end else begin
      h_eff = HW'(out_height_q);
    end
  end

  // --------------------------------------------------------------------------
  // Position counters and column re-index divider
  // --------------------------------------------------------------------------
  ybd_state_e      state_q;
  logic [ICW-1:0]  ic_q;
  logic [ICW-1:0]  col_q;
  logic [FW-1:0]   sub_q;
  logic [FW-1:0]   rib_q;
  logic [ROW_W-1:0] row_q;
  logic [ICW-1:0]  div_dq_q;
  logic [FW-1:0]   div_rem_q;
  logic [CNTW-1:0] div_cnt_q;

  logic [FIFO_PW:0] resv_q;
  logic             in_acc;
  logic             out_pop;

  assign pix_in.ready = (state_q == ST_RUN) && (resv_q != (FIFO_PW + 1)'(FIFO_DEPTH));
  assign in_acc       = pix_in.valid && pix_in.ready;

  // Counters as the current pixel sees them: anything past its bound is zero.
  logic             wrap_col;
  logic [ICW-1:0]   e_ic;
  logic [ICW-1:0]   e_col;
  logic [FW-1:0]    e_sub;
  logic [FW-1:0]    e_rib;
  logic [ROW_W-1:0] e_row;
  logic             sub_last, col_last, rib_last, row_last;
  logic             cur_first, cur_last, cur_eof;
  logic [ICW-1:0]   ic_n, col_n;
  logic [FW-1:0]    sub_n, rib_n;
  logic [ROW_W-1:0] row_n;

  always_comb begin
    wrap_col = CMPW'(col_q) >= CMPW'(w_eff);
    e_ic     = wrap_col ? '0 : ic_q;
    e_col    = wrap_col ? '0 : col_q;
    e_sub    = wrap_col ? '0 : sub_q;
    e_rib    = (rib_q >= f_eff) ? '0 : rib_q;
    e_row    = (HW'(row_q) >= h_eff) ? '0 : row_q;

    sub_last = e_sub == f_eff - FW'(1);
    rib_last = e_rib == f_eff - FW'(1);
    col_last = CMPW'(e_col) + CMPW'(1) == CMPW'(w_eff);
    row_last = HW'(e_row) + HW'(1) == h_eff;

    cur_first = (e_rib == '0) && (e_sub == '0);
    cur_last  = rib_last && sub_last;
    cur_eof   = cur_last && row_last && col_last;

    // Advance past the current pixel.
    sub_n = e_sub + FW'(1);
    col_n = e_col;
    ic_n  = e_ic + ICW'(1);
    rib_n = e_rib;
    row_n = e_row;
    if (sub_last) begin
      sub_n = '0;
      col_n = e_col + ICW'(1);
      if (col_last) begin
        col_n = '0;
        ic_n  = '0;
        if (rib_last) begin
          rib_n = '0;
          row_n = row_last ? '0 : e_row + ROW_W'(1);
        end else begin
          rib_n = e_rib + FW'(1);
        end
      end
    end
  end

  // One restoring step of pixel column divided by the block factor.
  logic [FW:0]    rem_sh;
  logic           div_ge;
  logic [FW:0]    rem_diff;
  logic [FW-1:0]  rem_nx;
  logic [ICW-1:0] dq_nx;

  always_comb begin
    rem_sh   = {div_rem_q, div_dq_q[ICW-1]};
    div_ge   = rem_sh >= {1'b0, f_eff};
    rem_diff = rem_sh - {1'b0, f_eff};
    rem_nx   = div_ge ? rem_diff[FW-1:0] : rem_sh[FW-1:0];
    dq_nx    = {div_dq_q[ICW-2:0], div_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      ic_q      <= '0;
      col_q     <= '0;
      sub_q     <= '0;
      rib_q     <= '0;
      row_q     <= '0;
      div_dq_q  <= '0;
      div_rem_q <= '0;
      div_cnt_q <= '0;
    end else if (cfg_wr) begin
      // The block factor may have changed: rebuild column and phase from ic.
      state_q   <= ST_DIV;
      div_dq_q  <= ic_q;
      div_rem_q <= '0;
      div_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (in_acc) begin
            ic_q  <= ic_n;
            col_q <= col_n;
            sub_q <= sub_n;
            rib_q <= rib_n;
            row_q <= row_n;
          end
        end
        ST_DIV: begin
          div_dq_q  <= dq_nx;
          div_rem_q <= rem_nx;
          div_cnt_q <= div_cnt_q + CNTW'(1);
          if (div_cnt_q == CNTW'(ICW - 1)) begin
            col_q   <= dq_nx;
            sub_q   <= rem_nx;
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: color conversion and accumulator read
  // --------------------------------------------------------------------------
  yuv_t yuv_in;

  always_comb begin
    yuv_in.y = Y_R * 32'(pix_in.red) + Y_G * 32'(pix_in.green) + Y_B * 32'(pix_in.blue);
    yuv_in.u = U_B * 32'(pix_in.blue) - U_R * 32'(pix_in.red) - U_G * 32'(pix_in.green);
    yuv_in.v = V_R * 32'(pix_in.red) - V_G * 32'(pix_in.green) - V_B * 32'(pix_in.blue);
  end

  logic          s1_vld_q;
  logic          s1_first_q, s1_last_q, s1_eof_q;
  logic [AW-1:0] s1_addr_q;
  yuv_t          s1_yuv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_first_q <= cur_first;
      s1_last_q  <= cur_last;
      s1_eof_q   <= cur_eof;
      s1_addr_q  <= e_col[AW-1:0];
      s1_yuv_q   <= yuv_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: accumulate and write back, with forwarding of the last write
  // --------------------------------------------------------------------------
  logic [YW-1:0] ram_rdata;
  yuv_t          acc_old;
  yuv_t          acc_new;
  logic          fwd_vld_q;
  logic [AW-1:0] fwd_addr_q;
  yuv_t          fwd_data_q;

  ybd_ram #(
    .WIDTH (YW),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_addr_q),
    .wdata_i (acc_new),
    .re_i    (in_acc),
    .raddr_i (e_col[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    acc_old = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : yuv_t'(ram_rdata);
    if (s1_first_q) begin
      acc_new = s1_yuv_q;
    end else begin
      acc_new.y = acc_old.y + s1_yuv_q.y;
      acc_new.u = acc_old.u + s1_yuv_q.u;
      acc_new.v = acc_old.v + s1_yuv_q.v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= acc_new;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale the block sums by the reciprocal of the block area
  // --------------------------------------------------------------------------
  logic        s2_vld_q, s2_eof_q;
  yuv_t        s2_sum_q;
  logic [16:0] recip;
  logic signed [48:0] prod_y, prod_u, prod_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && s1_last_q) begin
      s2_eof_q <= s1_eof_q;
      s2_sum_q <= acc_new;
    end
  end

  assign recip = recip_q16(5'(f_eff));

  // Round half up, then floor: add one half in Q16 and drop 16 bits.
  always_comb begin
    prod_y = $signed(s2_sum_q.y) * $signed({1'b0, recip}) + 49'sd32768;
    prod_u = $signed(s2_sum_q.u) * $signed({1'b0, recip}) + 49'sd32768;
    prod_v = $signed(s2_sum_q.v) * $signed({1'b0, recip}) + 49'sd32768;
  end

  // --------------------------------------------------------------------------
  // Stage 3: YUV to RGB products
  // --------------------------------------------------------------------------
  logic               s3_vld_q, s3_eof_q;
  logic signed [32:0] s3_ya_q, s3_ua_q, s3_va_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      s3_eof_q <= s2_eof_q;
      s3_ya_q  <= prod_y[48:16];
      s3_ua_q  <= prod_u[48:16];
      s3_va_q  <= prod_v[48:16];
    end
  end

  logic               s4_vld_q, s4_eof_q;
  logic signed [32:0] s4_ya_q;
  logic signed [49:0] s4_rv_q, s4_gu_q, s4_gv_q, s4_bu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      s4_eof_q <= s3_eof_q;
      s4_ya_q  <= s3_ya_q;
      s4_rv_q  <= 50'(s3_va_q) * R_V;
      s4_gu_q  <= 50'(s3_ua_q) * G_U;
      s4_gv_q  <= 50'(s3_va_q) * G_V;
      s4_bu_q  <= 50'(s3_ua_q) * B_U;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: channel sums, clamp to bytes
  // --------------------------------------------------------------------------
  logic signed [51:0] base_q28, r_q28, g_q28, b_q28;
  out_pix_t           push_pix;

  always_comb begin
    base_q28              = 52'(s4_ya_q) <<< 14;
    r_q28                 = base_q28 + 52'(s4_rv_q);
    g_q28                 = base_q28 - 52'(s4_gu_q) - 52'(s4_gv_q);
    b_q28                 = base_q28 + 52'(s4_bu_q);
    push_pix.out_red      = to_byte(r_q28);
    push_pix.out_green    = to_byte(g_q28);
    push_pix.out_blue     = to_byte(b_q28);
    push_pix.end_of_frame = s4_eof_q;
  end

  // --------------------------------------------------------------------------
  // Output queue with slot reservation at input acceptance
  // --------------------------------------------------------------------------
  out_pix_t           fifo_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wptr_q, rptr_q;
  logic [FIFO_PW:0]   fifo_cnt_q;
  logic               resv_inc;

  assign out_pop  = pix_out.valid && pix_out.ready;
  assign resv_inc = in_acc && cur_last;

  always_ff @(posedge clk_i) begin
    if (s4_vld_q) begin
      fifo_q[wptr_q] <= push_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      fifo_cnt_q <= '0;
      resv_q     <= '0;
    end else begin
      if (s4_vld_q) begin
        wptr_q <= wptr_q + FIFO_PW'(1);
      end
      if (out_pop) begin
        rptr_q <= rptr_q + FIFO_PW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (FIFO_PW + 1)'(s4_vld_q) - (FIFO_PW + 1)'(out_pop);
      resv_q     <= resv_q + (FIFO_PW + 1)'(resv_inc) - (FIFO_PW + 1)'(out_pop);
    end
  end

  assign pix_out.valid        = fifo_cnt_q != '0;
  assign pix_out.out_red      = fifo_q[rptr_q].out_red;
  assign pix_out.out_green    = fifo_q[rptr_q].out_green;
  assign pix_out.out_blue     = fifo_q[rptr_q].out_blue;
  assign pix_out.end_of_frame = fifo_q[rptr_q].end_of_frame;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEVER(a_fifo_above_resv, clk_i, rst_ni, fifo_cnt_q > resv_q, "queue holds unreserved results")
  `ASSERT_PROP(a_sub_in_block, clk_i, rst_ni, (state_q == ST_RUN) |-> (sub_q < f_eff), "column phase not below block factor")
  `ASSERT_PROP(a_addr_in_row, clk_i, rst_ni, s1_vld_q |-> (CMPW'(s1_addr_q) < CMPW'(w_eff)), "accumulator address beyond output width")
  `ASSERT_PROP(a_div_bounded, clk_i, rst_ni, (state_q == ST_DIV) |-> (div_cnt_q < CNTW'(ICW)), "divider ran past its last step")

endmodule

`default_nettype wire

### tb/sv/tb_yuv_box_downsampler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yuv_box_downsampler_top
// Self-checking testbench of the YUV box downsampler. RGB pixels are streamed
// in raster order under several register settings. A predictor inside the
// bench follows the block's fixed-point arithmetic and position counters.
// Every output transaction is checked against the oldest predicted pixel.
// ----------------------------------------------------------------------------

module tb_yuv_box_downsampler_top;
  import ybd_pkg::*;

  localparam int WIDTH_LIMIT  = 1024;
  localparam int FACTOR_LIMIT = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PIXELS = 1100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ybd_pix_in_if  pix_in_bus ();
  ybd_pix_out_if pix_out_bus ();

  yuv_box_downsampler_top #(
    .MAX_OUT_WIDTH (WIDTH_LIMIT),
    .MAX_FACTOR    (FACTOR_LIMIT)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_in_bus),
    .pix_out (pix_out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock: 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Register copies as the block holds them.
  logic [10:0] cfg_width  = 11'd1;
  logic [10:0] cfg_height = 11'd1;
  logic [3:0]  cfg_factor = 4'd1;

  // Predicted accumulator rows and stream position.
  logic [31:0] luma_acc [WIDTH_LIMIT];
  logic [31:0] chroma_u_acc [WIDTH_LIMIT];
  logic [31:0] chroma_v_acc [WIDTH_LIMIT];
  int unsigned in_col = 0;
  int unsigned blk_row = 0;
  int unsigned out_row = 0;

  out_pix_t pending_pixels [$];
  int pixel_mismatches = 0;
  int random_pixels = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // Register value as the block uses it: zero reads as one, large values saturate.
  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Rounded mean of a signed sum, Q16 reciprocal, floor of the shifted product.
  function automatic longint scaled_mean(input logic [31:0] sum, input longint recip);
    longint s;
    s = $signed(sum);
    return (s * recip + 64'sd32768) >>> 16;
  endfunction

  // Q28 channel value to a byte with saturation at both ends.
  function automatic logic [7:0] q28_to_byte(input longint q);
    longint t;
    if (q <= 0) return 8'd0;
    t = q >>> 28;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  // Predict the effect of one accepted input pixel; queue a result at block end.
  task automatic downsample_pixel(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    int unsigned fac, wid, hgt, row_end, col, sub;
    logic [31:0] y, u, v;
    longint area, recip, ya, ua, va, base;
    out_pix_t px;
    fac = clamp_reg(cfg_factor, FACTOR_LIMIT);
    wid = clamp_reg(cfg_width, WIDTH_LIMIT);
    hgt = clamp_reg(cfg_height, HEIGHT_LIMIT);
    row_end = fac * wid;
    if (in_col >= row_end) in_col = 0;
    if (blk_row >= fac) blk_row = 0;
    if (out_row >= hgt) out_row = 0;
    col = in_col / fac;
    sub = in_col % fac;

    y = 32'd4899 * r + 32'd9617 * g + 32'd1868 * b;
    u = 32'd7143 * b - 32'd2411 * r - 32'd4733 * g;
    v = 32'd10076 * r - 32'd8438 * g - 32'd1639 * b;

    // The first pixel of a block restarts the column sums.
    if (blk_row == 0 && sub == 0) begin
      luma_acc[col] = y;
      chroma_u_acc[col] = u;
      chroma_v_acc[col] = v;
    end else begin
      luma_acc[col] += y;
      chroma_u_acc[col] += u;
      chroma_v_acc[col] += v;
    end

    // The last pixel of a block produces one averaged output pixel.
    if (blk_row == fac - 1 && sub == fac - 1) begin
      area = fac * fac;
      recip = (65536 + area / 2) / area;
      ya = scaled_mean(luma_acc[col], recip);
      ua = scaled_mean(chroma_u_acc[col], recip);
      va = scaled_mean(chroma_v_acc[col], recip);
      base = ya * 16384;
      px.out_red = q28_to_byte(base + 18675 * va);
      px.out_green = q28_to_byte(base - 6466 * ua - 9513 * va);
      px.out_blue = q28_to_byte(base + 33294 * ua);
      px.end_of_frame = (out_row == hgt - 1) && (in_col == row_end - 1);
      pending_pixels.push_back(px);
    end

    in_col++;
    if (in_col >= row_end) begin
      in_col = 0;
      if (blk_row + 1 >= fac) begin
        blk_row = 0;
        out_row = (out_row + 1 >= hgt) ? 0 : out_row + 1;
      end else begin
        blk_row++;
      end
    end
  endtask

  // Compare one output transaction with the oldest predicted pixel.
  task automatic check_pixel();
    out_pix_t got, want;
    got.out_red = pix_out_bus.out_red;
    got.out_green = pix_out_bus.out_green;
    got.out_blue = pix_out_bus.out_blue;
    got.end_of_frame = pix_out_bus.end_of_frame;
    if (pending_pixels.size() == 0) begin
      pixel_mismatches++;
      if (pixel_mismatches <= 10)
        $display("Unexpected output pixel r=%0d g=%0d b=%0d eof=%0b at %0t",
                 got.out_red, got.out_green, got.out_blue, got.end_of_frame, $realtime);
    end else begin
      want = pending_pixels.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.end_of_frame !== want.end_of_frame) begin
        pixel_mismatches++;
        if (pixel_mismatches <= 10)
          $display("Pixel mismatch at %0t: expected r=%0d g=%0d b=%0d eof=%0b, got r=%0d g=%0d b=%0d eof=%0b",
                   $realtime, want.out_red, want.out_green, want.out_blue,
                   want.end_of_frame, got.out_red, got.out_green, got.out_blue,
                   got.end_of_frame);
      end
    end
  endtask

  // Output side: random back-pressure and checking of every transaction.
  initial begin
    pix_out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pix_out_bus.valid === 1'b1 && pix_out_bus.ready === 1'b1) check_pixel();
      pix_out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Send one pixel, with random idle cycles ahead of it; valid stays high after.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pix_in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in_bus.valid <= 1'b1;
    pix_in_bus.red <= r;
    pix_in_bus.green <= g;
    pix_in_bus.blue <= b;
    do @(posedge clk_i); while (pix_in_bus.ready !== 1'b1);
    downsample_pixel(r, g, b);
  endtask

  // Channel value biased toward the ends of the range.
  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(random_channel(), random_channel(), random_channel());
  endtask

  // Stop the stream and wait until every predicted pixel has come out.
  task automatic settle();
    pix_in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers back to back, setup then access phase each.
  task automatic program_registers(input logic [10:0] width, input logic [10:0] height,
                                   input logic [3:0] factor);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    idx[0] = REG_OUT_WIDTH;
    idx[1] = REG_OUT_HEIGHT;
    idx[2] = REG_BLOCK_FACTOR;
    val[0] = width;
    val[1] = height;
    val[2] = factor;
    for (int i = 0; i < 3; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx[i], 2'b00};
      pwdata <= val[i];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      case (idx[i])
        REG_OUT_WIDTH:    cfg_width = val[i][10:0];
        REG_OUT_HEIGHT:   cfg_height = val[i][10:0];
        REG_BLOCK_FACTOR: cfg_factor = val[i][3:0];
        default: ;
      endcase
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Zero registers read as one: every pixel is a whole frame. Pure colors
  // reach the clamps at both ends of each channel.
  task automatic test_color_extremes();
    program_registers(11'd0, 11'd0, 4'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    settle();
  endtask

  // Registers change in the middle of a frame: column, block row and output
  // row all sit at or beyond their new bounds and restart from zero.
  task automatic test_midframe_reconfig();
    program_registers(11'd1, 11'd2, 4'd2);
    send_random_pixels(7);
    settle();
    program_registers(11'd1, 11'd1, 4'd1);
    send_random_pixels(1);
    settle();
  endtask

  // A full row at the widest setting; only its last pixel ends the frame.
  task automatic test_full_width_row();
    program_registers(11'd2047, 11'd1, 4'd1);
    send_random_pixels(WIDTH_LIMIT);
    settle();
  endtask

  // One random setting followed by a whole number of block rows, so every
  // column is restarted before it is summed.
  task automatic run_random_phase();
    logic [10:0] w_reg, h_reg;
    logic [3:0]  f_reg;
    int unsigned fac, wid, block_row_pixels, rows;
    case ($urandom_range(0, 9))
      0: w_reg = 11'd0;
      1: w_reg = 11'($urandom_range(7, 20));
      default: w_reg = 11'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0: h_reg = 11'd0;
      1: h_reg = 11'($urandom_range(1024, 2047));
      default: h_reg = 11'($urandom_range(1, 4));
    endcase
    f_reg = 4'($urandom_range(0, 15));
    fac = clamp_reg(f_reg, FACTOR_LIMIT);
    wid = clamp_reg(w_reg, WIDTH_LIMIT);
    // Keep one block row within a few hundred pixels.
    if (fac * fac * wid > 400) begin
      wid = 400 / (fac * fac);
      if (wid == 0) wid = 1;
      w_reg = 11'(wid);
    end
    block_row_pixels = fac * fac * wid;
    rows = $urandom_range(1, (block_row_pixels >= 200) ? 1 : 200 / block_row_pixels);
    program_registers(w_reg, h_reg, f_reg);
    send_random_pixels(rows * block_row_pixels);
    random_pixels += rows * block_row_pixels;
    settle();
  endtask

  // Random settings across three idle profiles.
  task automatic test_random_frames();
    while (random_pixels < RANDOM_PIXELS) begin
      if (random_pixels >= 2 * RANDOM_PIXELS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (random_pixels >= RANDOM_PIXELS / 3) begin
        src_idle_pct = 81;
        snk_idle_pct = 37;
      end
      run_random_phase();
    end
  endtask

  // Main sequence.
  initial begin
    pix_in_bus.valid <= 1'b0;
    pix_in_bus.red <= 8'd0;
    pix_in_bus.green <= 8'd0;
    pix_in_bus.blue <= 8'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 4'd0;
    pwdata <= 32'd0;
    src_idle_pct = 37;
    snk_idle_pct = 81;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_color_extremes();
    test_midframe_reconfig();
    test_random_frames();
    test_full_width_row();

    if (pixel_mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
